// File: rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;
  localparam int OPERAND_W_DEF = 32;
  localparam int NUM_W = 64;
  localparam int DEN_W = 62;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_GCD,
    ST_DIVT,
    ST_DIVB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic div_sel_bot;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic gcd_done;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/rau_ctrl.sv
`default_nettype none
module rau_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rau_pkg::cmd_t      cmd,
  input  wire rau_pkg::stat_t stat
);
  import rau_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_GCD;
      ST_GCD: begin
        if (stat.zero) state_nxt = ST_OUT;
        else if (stat.gcd_done) state_nxt = ST_DIVT;
      end
      ST_DIVT: if (stat.div_done) state_nxt = ST_DIVB;
      ST_DIVB: if (stat.div_done) state_nxt = ST_OUT;
      ST_OUT:  if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state_r == ST_IDLE);
    ov_nxt = ov_r && !out_ready;
    case (state_r)
      ST_IDLE: cmd.load = in_valid;
      ST_MUL:  cmd.mul = 1'b1;
      ST_SUM: begin
        cmd.sum = 1'b1;
      end
      ST_GCD: begin
        cmd.gcd_step = 1'b1;
        cmd.div_init = stat.gcd_done;
      end
      ST_DIVT: begin
        cmd.div_step = 1'b1;
        cmd.div_init = stat.div_done;
      end
      ST_DIVB: begin
        cmd.div_step = 1'b1;
        cmd.div_sel_bot = 1'b1;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = ov_r;
endmodule
`default_nettype wire

// File: rtl/rau_dp.sv
`default_nettype none
module rau_dp #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_W_DEF
) (
  input  wire logic                      clk,
  input  wire logic [1:0]                in_kind,
  input  wire logic [OPERAND_WIDTH-1:0]  in_a,
  input  wire logic [OPERAND_WIDTH-1:0]  in_b,
  input  wire logic [OPERAND_WIDTH-1:0]  in_c,
  input  wire logic [OPERAND_WIDTH-1:0]  in_d,
  input  wire rau_pkg::cmd_t             cmd,
  output rau_pkg::stat_t                 stat,
  output logic [rau_pkg::NUM_W-1:0]      res_num,
  output logic [rau_pkg::DEN_W-1:0]      res_den
);
  import rau_pkg::*;
  localparam int W = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int CW = $clog2(NUM_W + 1);

  logic [1:0] kind_r;
  logic signed [W-1:0] a_r, b_r, c_r, d_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;
  logic [NUM_W-1:0] tm_r, bm_r, u_r, v_r, g, q_r, rem_r, nt_r, nb_r;
  logic neg_r, zero_r;
  logic [CW-1:0] sh_r, cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;

  function automatic logic signed [W-1:0] sat(input logic [W-1:0] x);
    logic signed [W-1:0] mn;
    mn = {1'b1, {(W-1){1'b0}}};
    return ($signed(x) == mn) ? (mn + 1'b1) : $signed(x);
  endfunction

  // ad or ac, bc, bd
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      a_r <= sat(in_a);
      b_r <= sat(in_b);
      c_r <= sat(in_c);
      d_r <= sat(in_d);
    end
    if (cmd.mul) begin
      p0_r <= (kind_r == KIND_MUL) ? a_r * c_r : a_r * d_r;
      p1_r <= b_r * c_r;
      p2_r <= b_r * d_r;
    end
  end

  logic signed [NUM_W-1:0] top, bot, e0, e1, e2;
  always_comb begin
    e0 = NUM_W'(p0_r);
    e1 = NUM_W'(p1_r);
    e2 = NUM_W'(p2_r);
    case (kind_r)
      KIND_ADD: begin top = e0 + e1; bot = e2; end
      KIND_SUB: begin top = e0 - e1; bot = e2; end
      KIND_MUL: begin top = e0;      bot = e2; end
      default:  begin top = e0;      bot = e1; end
    endcase
  end

  // binary gcd: strip common twos, then subtract-and-shift
  logic [NUM_W-1:0] du;
  assign du = (u_r > v_r) ? u_r - v_r : v_r - u_r;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      zero_r <= (top == 0) || (bot == 0);
      neg_r <= top[NUM_W-1] ^ bot[NUM_W-1];
      tm_r <= top[NUM_W-1] ? -top : top;
      bm_r <= bot[NUM_W-1] ? -bot : bot;
      u_r <= top[NUM_W-1] ? -top : top;
      v_r <= bot[NUM_W-1] ? -bot : bot;
      sh_r <= '0;
    end else if (cmd.gcd_step && !zero_r) begin
      if (u_r[0] == 1'b0 && v_r[0] == 1'b0) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        sh_r <= sh_r + 1'b1;
      end else if (u_r[0] == 1'b0) begin
        u_r <= u_r >> 1;
      end else if (v_r[0] == 1'b0) begin
        v_r <= v_r >> 1;
      end else if (u_r > v_r) begin
        u_r <= du >> 1;
      end else begin
        v_r <= du >> 1;
      end
    end
  end
  logic gcd_done;
  assign gcd_done = (u_r == v_r);
  assign g = u_r << sh_r;

  // restoring divider, shared for top and bottom
  logic [NUM_W:0] trial;
  assign trial = {rem_r, q_r[NUM_W-1]} - {1'b0, g};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      q_r <= cmd.div_step ? bm_r : tm_r;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[NUM_W]) begin
        rem_r <= trial[NUM_W-1:0];
        q_r <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[NUM_W-2:0], q_r[NUM_W-1]};
        q_r <= {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    // capture the last quotient bit even when the next division starts
    if (cmd.div_step && cnt_r == CW'(NUM_W - 1)) begin
      if (cmd.div_sel_bot) nb_r <= (!trial[NUM_W]) ? {q_r[NUM_W-2:0], 1'b1}
                                                    : {q_r[NUM_W-2:0], 1'b0};
      else nt_r <= (!trial[NUM_W]) ? {q_r[NUM_W-2:0], 1'b1}
                                   : {q_r[NUM_W-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      if (zero_r) begin
        num_r <= '0;
        den_r <= DEN_W'(1);
      end else begin
        num_r <= neg_r ? -nt_r : nt_r;
        den_r <= nb_r[DEN_W-1:0];
      end
    end
  end

  assign stat.zero = zero_r && cmd.gcd_step;
  assign stat.gcd_done = gcd_done && !zero_r;
  assign stat.div_done = (cnt_r == CW'(NUM_W - 1)) && cmd.div_step;
  assign res_num = num_r;
  assign res_den = den_r;
endmodule
`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
`default_nettype none
// Channel  | Direction | Ports
// in_      | input     | in_valid, in_ready, in_kind, in_first_*, in_second_*
// out_     | output    | out_valid, out_ready, out_result_numerator/_denominator
// One item at a time. An item passes through accept, multiply and sum, then the gcd
// steps (binary gcd, one shift or subtract per cycle), the top and bottom divisions
// in the shared restoring divider and the output step. A zero result skips the gcd
// steps and the dividers.
// Reset clears controller state.
// A stalled result beat holds in the output register; the next item may run
// and then waits in the output step, holding off the input, until it drains.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [OPERAND_WIDTH-1:0]     in_first_numerator,
  input  wire logic [OPERAND_WIDTH-1:0]     in_first_denominator,
  input  wire logic [OPERAND_WIDTH-1:0]     in_second_numerator,
  input  wire logic [OPERAND_WIDTH-1:0]     in_second_denominator,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rau_pkg::NUM_W-1:0]         out_result_numerator,
  output logic [rau_pkg::DEN_W-1:0]         out_result_denominator
);
  import rau_pkg::*;
  cmd_t  cmd;
  stat_t stat;

  // sequence the item through load, multiply, sum, gcd, divide, output
  rau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk,
    .in_kind,
    .in_a(in_first_numerator),
    .in_b(in_first_denominator),
    .in_c(in_second_numerator),
    .in_d(in_second_denominator),
    .cmd, .stat,
    .res_num(out_result_numerator),
    .res_den(out_result_denominator)
  );
endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import rau_pkg::*;

  localparam int OPW = 32;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [OPW-1:0] in_first_numerator = '0;
  logic [OPW-1:0] in_first_denominator = '0;
  logic [OPW-1:0] in_second_numerator = '0;
  logic [OPW-1:0] in_second_denominator = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [NUM_W-1:0] out_result_numerator;
  logic [DEN_W-1:0] out_result_denominator;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } fraction_t;

  fraction_t reduced_q[$];
  int mismatches = 0;
  int unexpected = 0;
  int results_seen = 0;
  int items_sent = 0;
  longint cycles = 0;
  // receiver hold-off request from the test, and the receiver's own count
  bit hold_req = 1'b0;
  int hold_cycles = 0;

  rational_arithmetic_unit #(.OPERAND_WIDTH(OPW)) uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  // Sign-extend and saturate the most negative value.
  function automatic longint widen(logic [OPW-1:0] raw);
    longint s;
    s = longint'(signed'(raw));
    if (s < -((64'sd1 <<< (OPW - 1)) - 1)) s = -((64'sd1 <<< (OPW - 1)) - 1);
    return s;
  endfunction

  function automatic fraction_t reduce_fraction(kind_t k, logic [OPW-1:0] a_r,
      logic [OPW-1:0] b_r, logic [OPW-1:0] c_r, logic [OPW-1:0] d_r);
    longint a, b, c, d, top, bottom;
    logic [63:0] tm, bm, x, y, r;
    fraction_t f;
    a = widen(a_r); b = widen(b_r); c = widen(c_r); d = widen(d_r);
    case (k)
      KIND_ADD: begin top = a * d + b * c; bottom = b * d; end
      KIND_SUB: begin top = a * d - b * c; bottom = b * d; end
      KIND_MUL: begin top = a * c; bottom = b * d; end
      default:  begin top = a * d; bottom = b * c; end
    endcase
    if (top == 0 || bottom == 0) begin
      f.num = '0;
      f.den = DEN_W'(1);
      return f;
    end
    tm = top < 0 ? -top : top;
    bm = bottom < 0 ? -bottom : bottom;
    x = tm; y = bm;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    tm = tm / x;
    bm = bm / x;
    f.num = ((top < 0) != (bottom < 0)) ? -tm : tm;
    f.den = bm[DEN_W-1:0];
    return f;
  endfunction

  // Receiver: stall on its own pattern, or hold off for a long stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_req && hold_cycles < 3000) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      if (!hold_req) hold_cycles <= 0;
      if ((cycles / 500) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    fraction_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (reduced_q.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing pending: %0d/%0d",
                   $signed(out_result_numerator), out_result_denominator);
      end else begin
        want = reduced_q.pop_front();
        if (want.num !== out_result_numerator || want.den !== out_result_denominator) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d, got %0d/%0d",
                     $signed(want.num), want.den,
                     $signed(out_result_numerator), out_result_denominator);
        end
      end
    end
  end

  // Offer one beat and wait for acceptance.
  task automatic send_fraction_pair(kind_t k, logic [OPW-1:0] a, logic [OPW-1:0] b,
                                    logic [OPW-1:0] c, logic [OPW-1:0] d);
    in_valid <= 1'b1;
    in_kind <= k;
    in_first_numerator <= a;
    in_first_denominator <= b;
    in_second_numerator <= c;
    in_second_denominator <= d;
    reduced_q.insert(reduced_q.size(), reduce_fraction(k, a, b, c, d));
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk);
  endtask

  function automatic logic [OPW-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return OPW'($urandom_range(0, 20)) - 10;
      1: return OPW'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0001);
      2: return OPW'($urandom_range(1, 1000)) * (($urandom_range(0, 1)) ? 1 : -1);
      default: return OPW'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic [OPW-1:0] vals[6];
    kind_t k;
    vals = '{32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd0};
    for (int i = 0; i < 4; i++) begin
      k = kind_t'(i);
      send_fraction_pair(k, vals[0], vals[1], vals[2], vals[0]);
      send_fraction_pair(k, vals[1], vals[3], vals[4], vals[2]);
      send_fraction_pair(k, vals[3], vals[0], vals[3], vals[1]);
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_zero_cases();
    // zero denominator on either side, zero divisor, exact cancellation
    send_fraction_pair(KIND_ADD, 32'd3, 32'd0, 32'd1, 32'd2);
    send_fraction_pair(KIND_MUL, 32'd3, 32'd5, 32'd1, 32'd0);
    send_fraction_pair(KIND_DIV, 32'd3, 32'd5, 32'd0, 32'd7);
    send_fraction_pair(KIND_SUB, 32'd2, 32'd4, 32'd1, 32'd2);
    send_fraction_pair(KIND_ADD, -32'sd1, 32'd3, 32'd2, -32'sd6);
    send_fraction_pair(KIND_MUL, 32'd0, 32'd0, 32'd0, 32'd0);
    send_fraction_pair(KIND_DIV, 32'd6, -32'sd4, -32'sd9, 32'd2);
    in_valid <= 1'b0;
  endtask

  task automatic test_random_bursts(int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      repeat ($urandom_range(1, 12)) begin
        if (sent < n) begin
          send_fraction_pair(kind_t'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                             rand_operand(), rand_operand());
          sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    in_valid <= 1'b0;
  endtask

  task automatic test_backpressure();
    // hold the receiver while the sender keeps offering beats
    hold_req <= 1'b1;
    test_random_bursts(8);
    wait (hold_cycles >= 3000);
    hold_req <= 1'b0;
  endtask

  task automatic drain_pending();
    in_valid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_cases();
    drain_pending();
    test_backpressure();
    drain_pending();
    test_random_bursts(1030);
    drain_pending();
    $display("covered %0d items, %0d results: all four operations, operand extremes,",
             items_sent, results_seen);
    $display("zero denominators and numerators, random stalls and one long hold-off");
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches, %0d extra beats, %0d left", mismatches, unexpected,
               reduced_q.size());
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: rational_arithmetic_unit.f
rtl/rau_pkg.sv
rtl/rau_ctrl.sv
rtl/rau_dp.sv
rtl/rational_arithmetic_unit.sv
tb/tb_top.sv
